FILE: hw/rtl/rwl_pkg.sv
// shared types, codes and constants of the reader-writer lock arbiter
package rwl_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int MAX_THREADS     = 256;
	localparam int THREAD_W        = 8;
	localparam int COUNT_W         = 9;
	localparam int STATUS_W        = 3;

	localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(511);
	localparam logic [COUNT_W-1:0] COUNT_LIMIT =
		COUNT_W'((MAX_THREADS < 511) ? MAX_THREADS : 511);

	typedef enum logic [1:0] {
		OP_ENTER_READ  = 2'd0,
		OP_ENTER_WRITE = 2'd1,
		OP_EXIT_READ   = 2'd2,
		OP_EXIT_WRITE  = 2'd3
	} op_t;

	localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_WOKEN    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NONE     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_MISUSE   = 3'd5;

	typedef struct packed {
		op_t                 op;
		logic [THREAD_W-1:0] thread;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [THREAD_W-1:0] granted_thread;
		logic [COUNT_W-1:0]  active_readers;
		logic                last;
	} res_t;

endpackage

FILE: hw/rtl/rwl_front.sv
// front end: takes request words, decodes the operation, holds them in a two-entry queue
module rwl_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        in_op,
	input  logic [7:0]        in_thread,
	output logic              cmd_valid,
	output rwl_pkg::cmd_t     cmd,
	input  logic              cmd_pop
);
	import rwl_pkg::*;

	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	cmd_t       dec;

	always_comb begin
		dec.thread = in_thread;
		case (in_op)
			OP_ENTER_READ:  dec.op = OP_ENTER_READ;
			OP_ENTER_WRITE: dec.op = OP_ENTER_WRITE;
			OP_EXIT_READ:   dec.op = OP_EXIT_READ;
			default:        dec.op = OP_EXIT_WRITE;
		endcase
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, cmd_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/rwl_waitq.sv
// circular wait queue of thread ids with registered head read
module rwl_waitq #(
	parameter int QUEUE_DEPTH = rwl_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  logic [rwl_pkg::THREAD_W-1:0]       push_data,
	input  logic                               pop,
	output logic [rwl_pkg::THREAD_W-1:0]       front,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]   fill,
	output logic                               full
);
	import rwl_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int FW = $clog2(QUEUE_DEPTH + 1);

	logic [THREAD_W-1:0] mem [QUEUE_DEPTH];
	logic [AW-1:0]       head_q;
	logic [FW-1:0]       fill_q;
	logic [THREAD_W-1:0] front_q;
	logic [AW-1:0]       head_nx;
	logic [AW-1:0]       rd_addr;
	logic [AW:0]         tail_sum;
	logic [AW-1:0]       tail;

	assign head_nx = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign rd_addr = pop ? head_nx : head_q;

	// head + fill stays below twice the depth
	assign tail_sum = {1'b0, head_q} + (AW+1)'(fill_q);
	assign tail     = (tail_sum >= (AW+1)'(QUEUE_DEPTH)) ?
		AW'(tail_sum - (AW+1)'(QUEUE_DEPTH)) : tail_sum[AW-1:0];

	assign front = front_q;
	assign fill  = fill_q;
	assign full  = (fill_q == FW'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail] <= push_data;
		end
		front_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_nx;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + FW'(1);
				2'b01:   fill_q <= fill_q - FW'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (fill_q != '0))
		else $error("pop from empty wait queue");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full wait queue");

	a_no_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && pop))
		else $error("push and pop in one cycle");

endmodule

FILE: hw/rtl/rwl_back.sv
// back end: lock state, wait queues and the result register
module rwl_back #(
	parameter int QUEUE_DEPTH = rwl_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  rwl_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          res_valid,
	input  logic          res_ready,
	output rwl_pkg::res_t res
);
	import rwl_pkg::*;

	localparam int FW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_EXEC  = 2'd1;
	localparam logic [1:0] S_BURST = 2'd2;

	logic [1:0]          state_q, state_d;
	cmd_t                cmd_q;
	logic [COUNT_W-1:0]  rc_q, rc_d;
	logic                wa_q, wa_d;
	logic                res_valid_q;
	res_t                res_q, res_d;
	logic                load;
	logic                slot_free;

	logic                r_push, r_pop, r_full;
	logic                w_push, w_pop, w_full;
	logic [THREAD_W-1:0] r_front, w_front;
	logic [FW-1:0]       r_fill, w_fill;

	rwl_waitq #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_rq (
		.clk(clk), .arst_n(arst_n), .push(r_push), .push_data(cmd_q.thread),
		.pop(r_pop), .front(r_front), .fill(r_fill), .full(r_full)
	);

	rwl_waitq #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_wq (
		.clk(clk), .arst_n(arst_n), .push(w_push), .push_data(cmd_q.thread),
		.pop(w_pop), .front(w_front), .fill(w_fill), .full(w_full)
	);

	assign slot_free = !res_valid_q || res_ready;
	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		state_d = state_q;
		rc_d    = rc_q;
		wa_d    = wa_q;
		r_push  = 1'b0;
		r_pop   = 1'b0;
		w_push  = 1'b0;
		w_pop   = 1'b0;
		load    = 1'b0;
		res_d.status         = ST_NONE;
		res_d.granted_thread = cmd_q.thread;
		res_d.last           = 1'b1;

		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (slot_free) begin
					load    = 1'b1;
					state_d = S_IDLE;
					case (cmd_q.op)
						OP_ENTER_READ: begin
							if (!wa_q && w_fill == '0) begin
								if (rc_q >= COUNT_LIMIT) begin
									res_d.status = ST_REJECTED;
								end else begin
									rc_d         = rc_q + COUNT_W'(1);
									res_d.status = ST_GRANTED;
								end
							end else if (r_full) begin
								res_d.status = ST_REJECTED;
							end else begin
								r_push       = 1'b1;
								res_d.status = ST_QUEUED;
							end
						end
						OP_ENTER_WRITE: begin
							if (!wa_q && rc_q == '0) begin
								wa_d         = 1'b1;
								res_d.status = ST_GRANTED;
							end else if (w_full) begin
								res_d.status = ST_REJECTED;
							end else begin
								w_push       = 1'b1;
								res_d.status = ST_QUEUED;
							end
						end
						OP_EXIT_READ: begin
							if (rc_q == '0) begin
								res_d.status = ST_MISUSE;
							end else begin
								rc_d = rc_q - COUNT_W'(1);
								// last reader out hands the lock to the front writer
								if (rc_q == COUNT_W'(1) && w_fill != '0) begin
									w_pop                = 1'b1;
									wa_d                 = 1'b1;
									res_d.status         = ST_WOKEN;
									res_d.granted_thread = w_front;
								end
							end
						end
						default: begin
							if (!wa_q) begin
								res_d.status = ST_MISUSE;
							end else begin
								wa_d = 1'b0;
								if (r_fill != '0) begin
									r_pop                = 1'b1;
									rc_d = (rc_q < COUNT_MAX) ? rc_q + COUNT_W'(1) : rc_q;
									res_d.status         = ST_WOKEN;
									res_d.granted_thread = r_front;
									res_d.last           = (r_fill == FW'(1));
									if (r_fill != FW'(1)) begin
										state_d = S_BURST;
									end
								end else if (w_fill != '0) begin
									w_pop                = 1'b1;
									wa_d                 = 1'b1;
									res_d.status         = ST_WOKEN;
									res_d.granted_thread = w_front;
								end
							end
						end
					endcase
				end
			end
			S_BURST: begin
				// one waiting reader granted per word
				if (slot_free) begin
					load                 = 1'b1;
					r_pop                = 1'b1;
					rc_d = (rc_q < COUNT_MAX) ? rc_q + COUNT_W'(1) : rc_q;
					res_d.status         = ST_WOKEN;
					res_d.granted_thread = r_front;
					res_d.last           = (r_fill == FW'(1));
					if (r_fill == FW'(1)) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		res_d.active_readers = rc_d;
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (load) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rc_q        <= '0;
			wa_q        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rc_q    <= rc_d;
			wa_q    <= wa_d;
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(wa_q && rc_q != '0))
		else $error("writer holds lock while readers hold it");

	a_burst_has_readers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BURST) |-> (r_fill != '0 && !wa_q))
		else $error("reader burst with empty queue or writer active");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_ready) |=> (res_valid_q && $stable(res_q)))
		else $error("result word changed while stalled");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(r_fill <= FW'(QUEUE_DEPTH)) && (w_fill <= FW'(QUEUE_DEPTH)))
		else $error("wait queue fill beyond depth");

endmodule

FILE: hw/rtl/reader_writer_lock_arbiter.sv
// top level of the reader-writer lock arbiter
//
// channel  dir  tdata bits (low first)                              tlast
// s_axis   in   operation[1:0], thread[9:2], zero pad to 16         -
// m_axis   out  status[2:0], granted_thread[10:3],                  last
//               active_readers[19:11], zero pad to 24
//
// each request word is loaded from the front queue in the idle state, while the wait
// queue heads are read; the execute state then updates the lock and writes the result
// a writer release with waiting readers grants one reader per cycle while output is free
// arst_n clears the lock state, queue pointers and all valid flags
// a two-entry request queue and the result register let input and output stall apart
module reader_writer_lock_arbiter #(
	parameter int QUEUE_DEPTH = rwl_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // operation, thread
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // status, granted_thread, active_readers
	output logic        m_axis_tlast
);
	import rwl_pkg::*;

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;
	res_t res;

	rwl_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_op(s_axis_tdata[1:0]), .in_thread(s_axis_tdata[9:2]),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
	);

	rwl_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
	);

	assign m_axis_tdata = {4'd0, res.active_readers, res.granted_thread, res.status};
	assign m_axis_tlast = res.last;

endmodule
